### src/assert_macros.svh
// Assertion macros used by the top level of the binarizer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge, suspended while reset is asserted.
`define WGMB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define WGMB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### src/wgmb_pkg.sv
// Shared types and constants of the weighted group midrange binarizer.
package wgmb_pkg;

  // Sizes
  localparam int unsigned DEPTH_DEF   = 64;
  localparam int unsigned SAMPLE_W    = 8;
  localparam int unsigned NUM_SAMPLES = 9;
  localparam int unsigned CENTER_POS  = 4;
  localparam int unsigned WEIGHT_W    = 16;
  localparam int unsigned RING_W      = 11;  // sum of eight bytes
  localparam int unsigned SUM_W       = 28;
  localparam int unsigned THR_W       = 27;
  localparam int unsigned GIDX_W      = 6;
  localparam int unsigned CFG_IDX_W   = 8;
  localparam int unsigned IN_DATA_W   = 72;
  localparam int unsigned OUT_DATA_W  = 40;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_RING_WEIGHT   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_WEIGHT = 8'd1;

  // Reset values
  localparam logic signed [WEIGHT_W-1:0] RING_WEIGHT_RST   = 16'sd1;
  localparam logic signed [WEIGHT_W-1:0] CENTER_WEIGHT_RST = 16'sd8;
  localparam logic signed [SUM_W-1:0]    MIN_RST           = 28'sh7FF_FFFF;
  localparam logic signed [SUM_W-1:0]    MAX_RST           = '0;

  // Controller states
  typedef enum logic [1:0] {
    ST_LOAD,     // groups are taken in and stored
    ST_THRESH,   // threshold computed, first read issued
    ST_CAPTURE,  // read data arrives, result register loaded
    ST_HOLD      // result offered downstream
  } state_e;

  // Group leaving the weighting pipeline
  typedef struct packed {
    logic                     vld;
    logic                     last;
    logic signed [SUM_W-1:0]  sum;
  } grp_t;

endpackage

### src/weighted_group_midrange_binarizer.sv
// Top level of the weighted group midrange binarizer.
//
// Input items arrive on s_axis: nine unsigned byte samples in tdata and the
// blob_end marker on tlast. Each group is weighted (ring weight on eight
// samples, centre weight on sample 4) and written to a DEPTH-entry sum store
// while a running maximum and minimum are kept. Groups past DEPTH are dropped
// and flagged. One group is taken per cycle while s_axis_tready is high; a group
// passes the ring-total and product registers before it is stored.
// After the blob_end group is accepted, s_axis_tready stays low until the
// blob has been drained. In the cycle after the last group is stored the
// threshold (max+min)/2 is formed, then each stored sum is read back and
// compared: the read is issued, the read data is loaded into the result
// register and the result is offered; the next read is issued only when
// the offered result is accepted. A stalled m_axis holds the result register
// and the emission index. The cfg port writes ring_weight (index 0) and
// center_weight (index 1); it is always ready.
// Reset restores the weights to 1 and 8, clears the blob state and returns
// to taking groups; the store itself is not cleared.
`include "assert_macros.svh"

module weighted_group_midrange_binarizer #(
  parameter int unsigned DEPTH = wgmb_pkg::DEPTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Group input
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // sample0[7:0], sample1[15:8], ... sample8[71:64]
  input  logic [wgmb_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  input  logic                                s_axis_tlast,   // blob_end
  // Result output
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // polar_bit[0], group_index[6:1], threshold_value[33:7], overflowed[34], zero[39:35]
  output logic [wgmb_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  output logic                                m_axis_tlast,   // run_end
  // Configuration writes
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [wgmb_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [wgmb_pkg::WEIGHT_W-1:0]       cfg_data_i
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  wgmb_pkg::state_e                     state_q, state_d;
  logic signed [wgmb_pkg::WEIGHT_W-1:0] ring_w_q, center_w_q;
  logic signed [wgmb_pkg::SUM_W-1:0]    max_q, min_q, thr_q;
  logic signed [wgmb_pkg::SUM_W:0]      mm_sum;
  logic signed [wgmb_pkg::SUM_W-1:0]    thr_d;
  logic [CNT_W-1:0]                     cnt_q;
  logic                                 ovf_q;
  logic [IDX_W-1:0]                     idx_q, idx_inc;
  logic                                 bit_q, last_q;
  logic                                 in_acc, out_acc, last_busy;
  logic                                 store_ok, is_last;
  logic                                 rd_en, ld_out, blob_clr, take_in;
  logic [IDX_W-1:0]                     rd_addr;
  logic [wgmb_pkg::SUM_W-1:0]           rd_data;
  wgmb_pkg::grp_t                       grp;

  assign in_acc  = s_axis_tvalid & s_axis_tready;
  assign out_acc = m_axis_tvalid & m_axis_tready;

  // Configuration registers
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_w_q   <= wgmb_pkg::RING_WEIGHT_RST;
      center_w_q <= wgmb_pkg::CENTER_WEIGHT_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        wgmb_pkg::REG_RING_WEIGHT:   ring_w_q   <= cfg_data_i;
        wgmb_pkg::REG_CENTER_WEIGHT: center_w_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Weighting pipeline
  wgmb_weight u_weight (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (in_acc),
    .samples_i   (s_axis_tdata),
    .last_i      (s_axis_tlast),
    .ring_w_i    (ring_w_q),
    .center_w_i  (center_w_q),
    .last_busy_o (last_busy),
    .grp_o       (grp)
  );

  assign store_ok = grp.vld & (cnt_q < CNT_W'(DEPTH));

  // Sum store
  wgmb_mem #(
    .DEPTH (DEPTH),
    .AW    (IDX_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (store_ok),
    .waddr_i (cnt_q[IDX_W-1:0]),
    .wdata_i (grp.sum),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // Midrange, truncated toward zero
  assign mm_sum = {max_q[wgmb_pkg::SUM_W-1], max_q} + {min_q[wgmb_pkg::SUM_W-1], min_q};
  assign thr_d  = wgmb_pkg::SUM_W'((mm_sum + (wgmb_pkg::SUM_W+1)'(mm_sum[wgmb_pkg::SUM_W])) >>> 1);

  assign idx_inc = idx_q + 1'b1;
  assign is_last = (CNT_W'(idx_q) + 1'b1) == cnt_q;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      wgmb_pkg::ST_LOAD:    if (grp.vld && grp.last) state_d = wgmb_pkg::ST_THRESH;
      wgmb_pkg::ST_THRESH:  state_d = wgmb_pkg::ST_CAPTURE;
      wgmb_pkg::ST_CAPTURE: state_d = wgmb_pkg::ST_HOLD;
      wgmb_pkg::ST_HOLD: begin
        if (m_axis_tready) begin
          state_d = last_q ? wgmb_pkg::ST_LOAD : wgmb_pkg::ST_CAPTURE;
        end
      end
      default: state_d = wgmb_pkg::ST_LOAD;
    endcase
  end

  // Controller outputs
  always_comb begin
    take_in       = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = '0;
    ld_out        = 1'b0;
    blob_clr      = 1'b0;
    m_axis_tvalid = 1'b0;
    unique case (state_q)
      wgmb_pkg::ST_LOAD:    take_in = ~last_busy & ~(grp.vld & grp.last);
      wgmb_pkg::ST_THRESH:  rd_en = 1'b1;
      wgmb_pkg::ST_CAPTURE: ld_out = 1'b1;
      wgmb_pkg::ST_HOLD: begin
        m_axis_tvalid = 1'b1;
        rd_en         = m_axis_tready & ~last_q;
        rd_addr       = idx_inc;
        blob_clr      = m_axis_tready & last_q;
      end
      default: ;
    endcase
  end

  assign s_axis_tready = take_in;

  // State, blob tracking and emission index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wgmb_pkg::ST_LOAD;
      max_q   <= wgmb_pkg::MAX_RST;
      min_q   <= wgmb_pkg::MIN_RST;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      if (blob_clr) begin
        max_q <= wgmb_pkg::MAX_RST;
        min_q <= wgmb_pkg::MIN_RST;
        cnt_q <= '0;
        ovf_q <= 1'b0;
      end else if (store_ok) begin
        cnt_q <= cnt_q + 1'b1;
        if (grp.sum > max_q) max_q <= grp.sum;
        if (grp.sum < min_q) min_q <= grp.sum;
      end else if (grp.vld) begin
        ovf_q <= 1'b1;
      end
      if (state_q == wgmb_pkg::ST_THRESH) begin
        idx_q <= '0;
      end else if (out_acc && !last_q) begin
        idx_q <= idx_inc;
      end
    end
  end

  // Threshold and result register
  always_ff @(posedge clk_i) begin
    if (state_q == wgmb_pkg::ST_THRESH) begin
      thr_q <= thr_d;
    end
    if (ld_out) begin
      bit_q  <= $signed(rd_data) > thr_q;
      last_q <= is_last;
    end
  end

  assign m_axis_tdata = {5'b0, ovf_q, thr_q[wgmb_pkg::THR_W-1:0],
                         wgmb_pkg::GIDX_W'(idx_q), bit_q};
  assign m_axis_tlast = last_q;

  // Checks
  `WGMB_ASSERT(a_cnt_bound, cnt_q <= CNT_W'(DEPTH), "group count past store depth")
  `WGMB_ASSERT(a_no_take_after_end, last_busy |-> !s_axis_tready,
               "group taken while a blob end is in flight")
  `WGMB_ASSERT(a_last_matches_count, (m_axis_tvalid && m_axis_tlast) |-> is_last,
               "run end does not match stored group count")
  `WGMB_ASSERT(a_clear_after_run, (out_acc && m_axis_tlast) |=> (cnt_q == '0 && !ovf_q),
               "blob state not cleared after the last result")

endmodule

### src/wgmb_weight.sv
// Two-stage weighting pipeline: ring total, then the two weight products.
module wgmb_weight (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        acc_i,
  input  logic [wgmb_pkg::IN_DATA_W-1:0]              samples_i,
  input  logic                                        last_i,
  input  logic signed [wgmb_pkg::WEIGHT_W-1:0]        ring_w_i,
  input  logic signed [wgmb_pkg::WEIGHT_W-1:0]        center_w_i,
  output logic                                        last_busy_o,
  output wgmb_pkg::grp_t                              grp_o
);

  logic                                  s1_vld_q, s1_last_q;
  logic [wgmb_pkg::RING_W-1:0]           ring_d, ring_q;
  logic [wgmb_pkg::SAMPLE_W-1:0]         ctr_q;
  logic                                  s2_vld_q, s2_last_q;
  logic signed [wgmb_pkg::SUM_W-1:0]     pr_d, pr_q;
  logic signed [24:0]                    pc_d, pc_q;

  // Sum of the eight ring samples
  always_comb begin
    ring_d = '0;
    for (int j = 0; j < wgmb_pkg::NUM_SAMPLES; j++) begin
      if (j != wgmb_pkg::CENTER_POS) begin
        ring_d = ring_d + wgmb_pkg::RING_W'(samples_i[j*wgmb_pkg::SAMPLE_W +: wgmb_pkg::SAMPLE_W]);
      end
    end
  end

  // Weight products, operands sign-extended to the product width
  assign pr_d = wgmb_pkg::SUM_W'(ring_w_i) * wgmb_pkg::SUM_W'($signed({1'b0, ring_q}));
  assign pc_d = 25'(center_w_i) * 25'($signed({1'b0, ctr_q}));

  // Valid and marker flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s1_last_q <= 1'b0;
      s2_vld_q  <= 1'b0;
      s2_last_q <= 1'b0;
    end else begin
      s1_vld_q  <= acc_i;
      s1_last_q <= acc_i & last_i;
      s2_vld_q  <= s1_vld_q;
      s2_last_q <= s1_last_q;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      ring_q <= ring_d;
      ctr_q  <= samples_i[wgmb_pkg::CENTER_POS*wgmb_pkg::SAMPLE_W +: wgmb_pkg::SAMPLE_W];
    end
    if (s1_vld_q) begin
      pr_q <= pr_d;
      pc_q <= pc_d;
    end
  end

  assign last_busy_o = s1_last_q | s2_last_q;
  assign grp_o.vld   = s2_vld_q;
  assign grp_o.last  = s2_last_q;
  assign grp_o.sum   = pr_q + wgmb_pkg::SUM_W'(pc_q);

endmodule

### src/wgmb_mem.sv
// Sum store: one write port, one read port with registered read data.
module wgmb_mem #(
  parameter int unsigned DEPTH = wgmb_pkg::DEPTH_DEF,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                              clk_i,
  input  logic                              we_i,
  input  logic [AW-1:0]                     waddr_i,
  input  logic [wgmb_pkg::SUM_W-1:0]        wdata_i,
  input  logic                              re_i,
  input  logic [AW-1:0]                     raddr_i,
  output logic [wgmb_pkg::SUM_W-1:0]        rdata_o
);

  logic [wgmb_pkg::SUM_W-1:0] mem [DEPTH];
  logic [wgmb_pkg::SUM_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
